// File: sv/sorted_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, operation codes, status codes and the cell command type.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Queue geometry.
    localparam int DEPTH      = 16;
    localparam int PRIO_BITS  = 8;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_W    = $clog2(DEPTH + 1);

    // Operation codes carried on the mode port.
    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_INSERT  = 2'd1,
        MODE_DEQUEUE = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // What every cell does in each cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_SHIFT  = 2'd3
    } cell_op_t;

    // Command broadcast to the whole chain.
    typedef struct packed {
        cell_op_t                     op;
        logic [VALUE_BITS-1:0]        value;
        logic [PRIO_BITS-1:0]         prio;
    } cell_cmd_t;

    // Entry handed between neighboring cells.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [PRIO_BITS-1:0]  prio;
    } entry_t;

endpackage

// File: sv/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue with append, priority insert, dequeue and clear, built as a
// chain of slot cells that shift in parallel.
//
//   Channel   Handshake        Ports
//   command   start / busy     mode, item_value, item_priority
//   result    done (strobe)    status, out_value, out_priority, occupancy
//
// One command is taken per cycle; busy stays low.
// The result shows in the cycle after the command transfer, for one cycle.
// The receiver cannot stall, so nothing ever holds the command side off.
// The insert point is found by a compare in every cell chained from the head.
// Reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic signed [31:0] item_value,
    input  logic [7:0]  item_priority,
    output logic        done,
    output logic [1:0]  status,
    output logic signed [31:0] out_value,
    output logic [7:0]  out_priority,
    output logic [4:0]  occupancy
);

    localparam int N = spq_pkg::DEPTH;

    logic                            accept;
    spq_pkg::mode_t                  mode_op;
    logic                            full;
    logic                            empty;
    logic [spq_pkg::COUNT_W-1:0]     count_reg;
    logic [spq_pkg::COUNT_W-1:0]     count_next;
    logic [1:0]                      status_next;
    spq_pkg::cell_cmd_t              cmd;
    logic [N:0]                      occ;
    logic [N:0]                      found;
    spq_pkg::entry_t                 entries [N];
    spq_pkg::entry_t                 zero_entry;

    logic                            done_reg;
    logic [1:0]                      status_reg;
    logic [31:0]                     value_reg;
    logic [7:0]                      prio_reg;
    logic [31:0]                     value_next;
    logic [7:0]                      prio_next;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign mode_op = spq_pkg::mode_t'(mode);
    assign full    = (count_reg == spq_pkg::COUNT_W'(N));
    assign empty   = (count_reg == '0);

    // Decode the command into a chain operation, the status and the new count.
    always_comb
    begin
        cmd.op      = spq_pkg::CELL_HOLD;
        cmd.value   = item_value;
        cmd.prio    = item_priority[spq_pkg::PRIO_BITS-1:0];
        count_next  = count_reg;
        status_next = spq_pkg::ST_OK;
        value_next  = '0;
        prio_next   = '0;
        if (accept)
        begin
            unique case (mode_op) inside
                spq_pkg::MODE_APPEND,
                spq_pkg::MODE_INSERT:
                begin
                    if (full)
                    begin
                        status_next = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.op     = (mode_op == spq_pkg::MODE_APPEND) ?
                                     spq_pkg::CELL_APPEND : spq_pkg::CELL_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                spq_pkg::MODE_DEQUEUE:
                begin
                    if (empty)
                    begin
                        status_next = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.op     = spq_pkg::CELL_SHIFT;
                        count_next = count_reg - 1'b1;
                        value_next = entries[0].value;
                        prio_next  = 8'(entries[0].prio);
                    end
                end
                spq_pkg::MODE_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Occupancy thermometer: slot k holds an entry when k is below the count.
    assign occ[0]   = 1'b1;
    assign found[0] = 1'b0;
    assign zero_entry = '0;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            spq_pkg::entry_t left_e;
            spq_pkg::entry_t right_e;

            assign occ[k+1] = (count_reg > spq_pkg::COUNT_W'(k));

            if (k == 0)
            begin : g_head
                assign left_e = zero_entry;
            end
            else
            begin : g_mid
                assign left_e = entries[k-1];
            end

            if (k == N - 1)
            begin : g_tail
                assign right_e = zero_entry;
            end
            else
            begin : g_body
                assign right_e = entries[k+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occ_left    ((k == 0) ? 1'b1 : occ[k]),
                .occ_self    (occ[k+1]),
                .found_in    (found[k]),
                .left_entry  (left_e),
                .right_entry (right_e),
                .found_out   (found[k+1]),
                .entry       (entries[k])
            );
        end
    endgenerate

    // Count and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= spq_pkg::ST_OK;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (accept)
            begin
                status_reg <= status_next;
            end
        end
    end

    // Result payload; loaded on each command transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value_next;
            prio_reg  <= prio_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_value    = value_reg;
    assign out_priority = prio_reg;
    assign occupancy    = 5'(count_reg);

    // The count never exceeds the queue depth.
    `SPQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= spq_pkg::COUNT_W'(N))
    // A clear always leaves an empty queue in its result.
    `SPQ_ASSERT_NEXT(a_clear_empty, clk, rst_n,
        accept && mode == spq_pkg::MODE_CLEAR, done && occupancy == '0)
    // A dequeue on an empty queue reports empty with a zero payload.
    `SPQ_ASSERT_NEXT(a_deq_empty, clk, rst_n,
        accept && mode == spq_pkg::MODE_DEQUEUE && empty,
        status == spq_pkg::ST_EMPTY && out_value == '0 && out_priority == '0)

endmodule

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one queue slot; keeps, loads, or takes a neighbor's entry each cycle.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic              clk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic              occ_left,
    input  logic              occ_self,
    input  logic              found_in,
    input  spq_pkg::entry_t   left_entry,
    input  spq_pkg::entry_t   right_entry,
    output logic              found_out,
    output spq_pkg::entry_t   entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    spq_pkg::entry_t new_entry;
    logic            tail_slot;
    logic            greater;

    // This slot is the first free one when it is empty and its left neighbor is occupied.
    assign tail_slot = occ_left && !occ_self;

    // A stored entry with a strictly greater priority marks the insert point.
    assign greater   = occ_self && (entry_reg.prio > cmd.prio);
    assign found_out = found_in || greater;

    assign new_entry.value = cmd.value;
    assign new_entry.prio  = cmd.prio;

    // Next slot contents for each command.
    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            spq_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            spq_pkg::CELL_APPEND:
            begin
                if (tail_slot)
                begin
                    entry_next = new_entry;
                end
            end
            spq_pkg::CELL_INSERT:
            begin
                if (found_in)
                begin
                    entry_next = left_entry;
                end
                else if (greater || tail_slot)
                begin
                    entry_next = new_entry;
                end
            end
            spq_pkg::CELL_SHIFT:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Slot storage needs no reset; occupancy is tracked by the count.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
